@@ src/atan2_table_interpolated_unit_defines.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the atan2 table unit
// Concurrent property shorthands clocked on clk_i and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef ATAN2_TABLE_INTERPOLATED_UNIT_DEFINES_SVH
`define ATAN2_TABLE_INTERPOLATED_UNIT_DEFINES_SVH

// Same-cycle implication.
`define A2TI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define A2TI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/atan2ti_pkg.sv @@
// -----------------------------------------------------------------------------
// atan2ti_pkg
// Shared types, fixed-point constants and the arctangent ROM contents.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atan2ti_pkg;

  // Ratio format: Q0.16 plus the exact value 1.0.
  localparam int unsigned FRACW = 16;
  localparam int unsigned ZW    = FRACW + 1;

  // Internal angle in units of 1e-9 rad.
  localparam int unsigned NANOW = 34;
  localparam int unsigned BASEW = 30;
  localparam int unsigned MAGW  = 33;
  localparam logic signed [NANOW-1:0] NANO_PI      = 34'sd3141592654;
  localparam logic signed [NANOW-1:0] NANO_HALF_PI = 34'sd1570796327;
  localparam logic signed [NANOW-1:0] NANO_TWO_PI  = 34'sd6283185307;
  localparam logic [29:0] SMALL_MUL = 30'd1000000000;

  // Arctangent ROM.
  localparam int unsigned ROM_LEN      = 257;
  localparam int unsigned ROMAW        = 9;
  localparam int unsigned IDXW         = 8;
  localparam int unsigned ROM_LAST_IDX = 255;
  localparam int unsigned DIFFW        = 22;

  // Conversion to Q3.14: q = floor((mag*32 + M_OFS) / DIVC).
  localparam int unsigned MW      = 38;
  localparam int unsigned MHIW    = 21;
  localparam int unsigned RECIPW  = 29;
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned PRODW   = MHIW + RECIPW;
  localparam int unsigned QW      = 17;
  localparam int unsigned DIVCW   = 21;
  localparam logic [MW-1:0]     M_OFS = 38'd976562;
  localparam logic [RECIPW-1:0] RECIP = 29'd288230376;
  localparam logic [DIVCW-1:0]  DIVC  = 21'd1953125;
  localparam int unsigned OUTW = 18;

  // Octant information carried alongside the ratio.
  typedef struct packed {
    logic zero;
    logic xgt;
    logic xneg;
    logic yneg;
  } oct_t;

  localparam logic [BASEW-1:0] ATAN_ROM [ROM_LEN] = '{
    30'd0, 30'd3921549, 30'd7842976, 30'd11764160,
    30'd15684990, 30'd19605330, 30'd23525070, 30'd27444090,
    30'd31362260, 30'd35279470, 30'd39195600, 30'd43110530,
    30'd47024130, 30'd50936290, 30'd54846900, 30'd58755820,
    30'd62662950, 30'd66568160, 30'd70471340, 30'd74372380,
    30'd78271140, 30'd82167520, 30'd86061410, 30'd89952670,
    30'd93841210, 30'd97726910, 30'd101609600, 30'd105489300,
    30'd109365800, 30'd113239000, 30'd117108700, 30'd120975000,
    30'd124837600, 30'd128696500, 30'd132551500, 30'd136402600,
    30'd140249600, 30'd144092400, 30'd147931000, 30'd151765200,
    30'd155594800, 30'd159419900, 30'd163240300, 30'd167055900,
    30'd170866500, 30'd174672200, 30'd178472800, 30'd182268100,
    30'd186058200, 30'd189842800, 30'd193622000, 30'd197395600,
    30'd201163400, 30'd204925500, 30'd208681800, 30'd212432000,
    30'd216176200, 30'd219914300, 30'd223646100, 30'd227371600,
    30'd231090700, 30'd234803300, 30'd238509300, 30'd242208600,
    30'd245901200, 30'd249586900, 30'd253265800, 30'd256937600,
    30'd260602400, 30'd264260000, 30'd267910400, 30'd271553500,
    30'd275189200, 30'd278817500, 30'd282438300, 30'd286051400,
    30'd289656900, 30'd293254700, 30'd296844700, 30'd300426800,
    30'd304000900, 30'd307567100, 30'd311125200, 30'd314675200,
    30'd318217000, 30'd321750600, 30'd325275800, 30'd328792700,
    30'd332301200, 30'd335801200, 30'd339292600, 30'd342775500,
    30'd346249700, 30'd349715300, 30'd353172100, 30'd356620100,
    30'd360059300, 30'd363489600, 30'd366911000, 30'd370323400,
    30'd373726800, 30'd377121100, 30'd380506400, 30'd383882500,
    30'd387249400, 30'd390607000, 30'd393955500, 30'd397294600,
    30'd400624400, 30'd403944800, 30'd407255800, 30'd410557400,
    30'd413849600, 30'd417132200, 30'd420405400, 30'd423668900,
    30'd426922900, 30'd430167300, 30'd433402100, 30'd436627200,
    30'd439842600, 30'd443048300, 30'd446244300, 30'd449430600,
    30'd452607000, 30'd455773800, 30'd458930700, 30'd462077800,
    30'd465215000, 30'd468342400, 30'd471460000, 30'd474567600,
    30'd477665400, 30'd480753200, 30'd483831200, 30'd486899200,
    30'd489957300, 30'd493005500, 30'd496043700, 30'd499071900,
    30'd502090200, 30'd505098500, 30'd508096800, 30'd511085200,
    30'd514063600, 30'd517032000, 30'd519990400, 30'd522938800,
    30'd525877200, 30'd528805600, 30'd531724100, 30'd534632500,
    30'd537531000, 30'd540419500, 30'd543298000, 30'd546166600,
    30'd549025100, 30'd551873800, 30'd554712400, 30'd557541100,
    30'd560359900, 30'd563168700, 30'd565967600, 30'd568756600,
    30'd571535700, 30'd574304800, 30'd577064100, 30'd579813500,
    30'd582553100, 30'd585282800, 30'd588002600, 30'd590712600,
    30'd593412800, 30'd596103200, 30'd598783900, 30'd601454700,
    30'd604115800, 30'd606767200, 30'd609408800, 30'd612040700,
    30'd614663000, 30'd617275500, 30'd619878400, 30'd622471700,
    30'd625055400, 30'd627629400, 30'd630193900, 30'd632748800,
    30'd635294200, 30'd637830100, 30'd640356500, 30'd642873400,
    30'd645380800, 30'd647878800, 30'd650367400, 30'd652846600,
    30'd655316500, 30'd657777000, 30'd660228200, 30'd662670100,
    30'd665102700, 30'd667526100, 30'd669940200, 30'd672345200,
    30'd674740900, 30'd677127600, 30'd679505100, 30'd681873500,
    30'd684232800, 30'd686583100, 30'd688924400, 30'd691256700,
    30'd693580000, 30'd695894300, 30'd698199800, 30'd700496400,
    30'd702784100, 30'd705063000, 30'd707333000, 30'd709594300,
    30'd711846900, 30'd714090700, 30'd716325800, 30'd718552300,
    30'd720770100, 30'd722979400, 30'd725180000, 30'd727372100,
    30'd729555700, 30'd731730700, 30'd733897400, 30'd736055500,
    30'd738205300, 30'd740346700, 30'd742479700, 30'd744604500,
    30'd746720900, 30'd748829100, 30'd750929100, 30'd753020800,
    30'd755104400, 30'd757179800, 30'd759247200, 30'd761306400,
    30'd763357600, 30'd765400800, 30'd767436000, 30'd769463300,
    30'd771482600, 30'd773494000, 30'd775497500, 30'd777493200,
    30'd779481100, 30'd781461200, 30'd783433500, 30'd785398300,
    30'd785398300
  };

endpackage

`default_nettype wire

@@ src/atan2ti_divider.sv @@
// -----------------------------------------------------------------------------
// atan2ti_divider
// Pipelined restoring divider: one quotient bit per stage, ratio in Q0.16.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atan2ti_divider #(
  parameter int unsigned DW = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic [DW-1:0]            num_i,
  input  wire logic [DW-1:0]            den_i,
  input  wire atan2ti_pkg::oct_t        oct_i,
  output logic                          vld_o,
  output logic [atan2ti_pkg::ZW-1:0]    z_o,
  output atan2ti_pkg::oct_t             oct_o
);
  import atan2ti_pkg::*;

  localparam int unsigned REMW = DW + 1;

  logic              vld_q [ZW];
  logic [REMW-1:0]   rem_q [ZW];
  logic [DW-1:0]     den_q [ZW];
  logic [ZW-1:0]     z_q   [ZW];
  oct_t              oct_q [ZW];

  for (genvar k = 0; k < ZW; k++) begin : g_stage
    logic            vld_in;
    logic [REMW-1:0] trial;
    logic [DW-1:0]   den_in;
    logic [ZW-1:0]   z_in;
    oct_t            oct_in;
    logic            ge;
    logic [REMW-1:0] rem_d;
    logic [ZW-1:0]   z_d;

    // The first stage compares the numerator itself; later stages shift in a zero.
    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign trial  = REMW'(num_i);
      assign den_in = den_i;
      assign z_in   = '0;
      assign oct_in = oct_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign trial  = {rem_q[k-1][REMW-2:0], 1'b0};
      assign den_in = den_q[k-1];
      assign z_in   = z_q[k-1];
      assign oct_in = oct_q[k-1];
    end

    // One compare-subtract decides this quotient bit.
    always_comb begin
      ge    = (trial >= REMW'(den_in));
      rem_d = ge ? (trial - REMW'(den_in)) : trial;
      z_d   = z_in;
      z_d[ZW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        z_q[k]   <= z_d;
        oct_q[k] <= oct_in;
      end
    end
  end

  assign vld_o = vld_q[ZW-1];
  assign z_o   = z_q[ZW-1];
  assign oct_o = oct_q[ZW-1];

endmodule

`default_nettype wire

@@ src/atan2ti_base.sv @@
// -----------------------------------------------------------------------------
// atan2ti_base
// Base angle of a ratio: direct small-ratio path or interpolated ROM lookup.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atan2ti_base #(
  parameter int unsigned TABLE_STEPS = 255
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       vld_i,
  input  wire logic [atan2ti_pkg::ZW-1:0] z_i,
  input  wire atan2ti_pkg::oct_t          oct_i,
  output logic                            vld_o,
  output logic [atan2ti_pkg::BASEW-1:0]   base_o,
  output atan2ti_pkg::oct_t               oct_o
);
  import atan2ti_pkg::*;

  localparam int unsigned TSW   = $clog2(TABLE_STEPS + 1);
  localparam int unsigned SCW   = ZW + TSW;
  localparam int unsigned IDXRW = SCW - FRACW;
  localparam int unsigned IDXEW = (IDXRW > IDXW) ? IDXRW : IDXW;
  localparam int unsigned SPW   = ZW + 30;
  localparam logic [TSW-1:0] STEPS = TSW'(TABLE_STEPS);
  localparam logic [SCW-1:0] HALF_STEP = SCW'(1) << (FRACW - 1);

  // Stage 1: scale the ratio by the table step count.
  logic            s1_vld_q;
  logic [SCW-1:0]  s1_scaled_q;
  logic [ZW-1:0]   s1_z_q;
  oct_t            s1_oct_q;

  // Stage 2: ROM neighbors, fraction and the small-ratio product.
  logic               s2_vld_q;
  logic [BASEW-1:0]   s2_lo_q, s2_hi_q;
  logic [FRACW-1:0]   s2_frac_q;
  logic               s2_small_q;
  logic [BASEW-1:0]   s2_sprod_q;
  oct_t               s2_oct_q;

  // Stage 3: interpolation product.
  logic               s3_vld_q;
  logic [BASEW-1:0]   s3_lo_q;
  logic [DIFFW-1:0]   s3_interp_q;
  logic               s3_small_q;
  logic [BASEW-1:0]   s3_sprod_q;
  oct_t               s3_oct_q;

  // Stage 4: final base angle.
  logic               s4_vld_q;
  logic [BASEW-1:0]   s4_base_q;
  oct_t               s4_oct_q;

  logic [SCW-1:0]     a;
  logic [IDXEW-1:0]   idx_ext;
  logic [IDXW-1:0]    idx;
  logic [SPW-1:0]     sprod;
  logic [DIFFW-1:0]   diff;
  logic [DIFFW+FRACW-1:0] dprod;

  // Table index and fraction, with the index held inside the ROM.
  always_comb begin
    a       = s1_scaled_q - HALF_STEP;
    idx_ext = IDXEW'(a[SCW-1:FRACW]);
    idx     = (idx_ext > IDXEW'(ROM_LAST_IDX)) ? IDXW'(ROM_LAST_IDX) : idx_ext[IDXW-1:0];
    sprod   = s1_z_q * SMALL_MUL;
  end

  // Difference between neighbors times the fraction.
  always_comb begin
    diff  = DIFFW'(s2_hi_q - s2_lo_q);
    dprod = diff * s2_frac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_scaled_q <= z_i * STEPS;
      s1_z_q      <= z_i;
      s1_oct_q    <= oct_i;

      s2_lo_q     <= ATAN_ROM[ROMAW'(idx)];
      s2_hi_q     <= ATAN_ROM[ROMAW'(idx) + ROMAW'(1)];
      s2_frac_q   <= a[FRACW-1:0];
      s2_small_q  <= (s1_scaled_q[SCW-1:FRACW] == '0);
      s2_sprod_q  <= sprod[FRACW+BASEW-1:FRACW];
      s2_oct_q    <= s1_oct_q;

      s3_lo_q     <= s2_lo_q;
      s3_interp_q <= dprod[DIFFW+FRACW-1:FRACW];
      s3_small_q  <= s2_small_q;
      s3_sprod_q  <= s2_sprod_q;
      s3_oct_q    <= s2_oct_q;

      s4_base_q   <= s3_small_q ? s3_sprod_q : (s3_lo_q + BASEW'(s3_interp_q));
      s4_oct_q    <= s3_oct_q;
    end
  end

  assign vld_o  = s4_vld_q;
  assign base_o = s4_base_q;
  assign oct_o  = s4_oct_q;

endmodule

`default_nettype wire

@@ src/atan2ti_post.sv @@
// -----------------------------------------------------------------------------
// atan2ti_post
// Octant fix-up, optional 2*pi lift and rounding of the angle to Q3.14.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atan2ti_post (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          range_mode_i,
  input  wire logic                          vld_i,
  input  wire logic [atan2ti_pkg::BASEW-1:0] base_i,
  input  wire atan2ti_pkg::oct_t             oct_i,
  output logic                               vld_o,
  output logic signed [atan2ti_pkg::OUTW-1:0] angle_o
);
  import atan2ti_pkg::*;

  localparam int unsigned NST = 8;

  logic                     vld_q [NST];
  logic signed [NANOW-1:0]  p1_ang_q, p2_ang_q;
  logic                     p3_neg_q, p4_neg_q, p5_neg_q, p6_neg_q, p7_neg_q;
  logic [MAGW-1:0]          p3_mag_q;
  logic [MW-1:0]            p4_m_q, p5_m_q, p6_m_q;
  logic [PRODW-1:0]         p5_prod_q;
  logic [QW-1:0]            p6_qe_q, p7_q_q;
  logic [MW-1:0]            p6_qd_q;
  logic signed [OUTW-1:0]   p8_ang_q;

  logic signed [NANOW-1:0]  b, ang;
  logic [PRODW-1:0]         prod;
  logic [QW-1:0]            qe;
  logic [MW-1:0]            qd;
  logic [MW-1:0]            r;

  // Map the base angle into its octant.
  always_comb begin
    b = $signed({{(NANOW - BASEW){1'b0}}, base_i});
    if (oct_i.zero) begin
      ang = '0;
    end else if (oct_i.xgt) begin
      if (!oct_i.xneg) begin
        ang = oct_i.yneg ? -b : b;
      end else begin
        ang = oct_i.yneg ? (b - NANO_PI) : (NANO_PI - b);
      end
    end else begin
      if (!oct_i.yneg) begin
        ang = oct_i.xneg ? (NANO_HALF_PI + b) : (NANO_HALF_PI - b);
      end else begin
        ang = oct_i.xneg ? (-NANO_HALF_PI - b) : (b - NANO_HALF_PI);
      end
    end
  end

  // Reciprocal estimate of the quotient and its back product.
  always_comb begin
    prod = p4_m_q[MW-1:MW-MHIW] * RECIP;
    qe   = p5_prod_q[RECIP_SH+QW-1:RECIP_SH];
    qd   = qe * DIVC;
    r    = p6_m_q - p6_qd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < NST; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_ang_q  <= ang;
      p2_ang_q  <= (range_mode_i && p1_ang_q < 0) ? (p1_ang_q + NANO_TWO_PI) : p1_ang_q;

      p3_neg_q  <= p2_ang_q[NANOW-1];
      p3_mag_q  <= p2_ang_q[NANOW-1] ? MAGW'(-p2_ang_q) : MAGW'(p2_ang_q);

      p4_neg_q  <= p3_neg_q;
      p4_m_q    <= {p3_mag_q, 5'b0} + M_OFS;

      p5_neg_q  <= p4_neg_q;
      p5_m_q    <= p4_m_q;
      p5_prod_q <= prod;

      p6_neg_q  <= p5_neg_q;
      p6_m_q    <= p5_m_q;
      p6_qe_q   <= qe;
      p6_qd_q   <= qd;

      // The estimate is low by at most one; one compare fixes it.
      p7_neg_q  <= p6_neg_q;
      p7_q_q    <= p6_qe_q + QW'(r >= MW'(DIVC));

      p8_ang_q  <= p7_neg_q ? $signed(OUTW'(0) - OUTW'(p7_q_q)) : $signed(OUTW'(p7_q_q));
    end
  end

  assign vld_o   = vld_q[NST-1];
  assign angle_o = p8_ang_q;

endmodule

`default_nettype wire

@@ src/atan2_table_interpolated_unit.sv @@
// -----------------------------------------------------------------------------
// atan2_table_interpolated_unit
// Four-quadrant arctangent of a (y, x) sample pair, result in Q3.14 radians.
// -----------------------------------------------------------------------------
// Usage:
//   Input beats (y_value_i, x_value_i) use in_valid_i / in_ready_o; result
//   beats (angle_o) use out_valid_o / out_ready_i. A beat moves when valid
//   and ready are both high at a rising edge of clk_i.
//   One beat is accepted per cycle while in_ready_o is high; every beat gives
//   exactly one result, in order. Stages: one setup stage, 17 divider stages
//   (one quotient bit each), four table and interpolation stages, eight fix-up
//   and rounding stages and the output register. range_mode is written
//   through cfg_we_i / cfg_wdata_i; the user must write it only while no beat
//   is in flight, which the block does not enforce. 1 lifts negative angles by 2*pi.
//   When out_ready_i is low, the result holds in the output register and the
//   pipeline keeps moving until one more result fills a skid register; then
//   in_ready_o drops until the skid drains. Nothing is lost or repeated.
//   Reset (rst_ni low, asynchronous) empties the pipeline and clears
//   range_mode.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atan2_table_interpolated_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TABLE_STEPS  = 255
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      y_value_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      x_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [atan2ti_pkg::OUTW-1:0]      angle_o
);
  import atan2ti_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;

  logic                   range_mode_q;
  logic                   en;
  logic [SW-1:0]          ya, xa;
  oct_t                   oct_d;

  logic                   pre_vld_q;
  logic [SW-1:0]          pre_num_q, pre_den_q;
  oct_t                   pre_oct_q;

  logic                   div_vld;
  logic [ZW-1:0]          div_z;
  oct_t                   div_oct;
  logic                   base_vld;
  logic [BASEW-1:0]       base;
  oct_t                   base_oct;
  logic                   post_vld;
  logic signed [OUTW-1:0] post_angle;

  logic                   out_vld_q, out_vld_d;
  logic                   skid_vld_q, skid_vld_d;
  logic signed [OUTW-1:0] out_angle_q, skid_angle_q;
  logic                   take, load_out_pipe, load_out_skid, load_skid;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      range_mode_q <= cfg_wdata_i;
    end
  end

  // The pipeline advances whenever the skid register is empty.
  assign en         = ~skid_vld_q;
  assign in_ready_o = en;

  // Magnitudes, octant flags and divider operands.
  always_comb begin
    ya = y_value_i[SW-1] ? ($unsigned(~y_value_i) + SW'(1)) : $unsigned(y_value_i);
    xa = x_value_i[SW-1] ? ($unsigned(~x_value_i) + SW'(1)) : $unsigned(x_value_i);
    oct_d.zero = (y_value_i == '0) && (x_value_i == '0);
    oct_d.xgt  = (xa > ya);
    oct_d.xneg = x_value_i[SW-1];
    oct_d.yneg = y_value_i[SW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en) begin
      pre_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_num_q <= oct_d.xgt ? ya : xa;
      pre_den_q <= oct_d.xgt ? xa : ya;
      pre_oct_q <= oct_d;
    end
  end

  atan2ti_divider #(
    .DW (SW)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pre_vld_q),
    .num_i  (pre_num_q),
    .den_i  (pre_den_q),
    .oct_i  (pre_oct_q),
    .vld_o  (div_vld),
    .z_o    (div_z),
    .oct_o  (div_oct)
  );

  atan2ti_base #(
    .TABLE_STEPS (TABLE_STEPS)
  ) u_base (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (div_vld),
    .z_i    (div_z),
    .oct_i  (div_oct),
    .vld_o  (base_vld),
    .base_o (base),
    .oct_o  (base_oct)
  );

  atan2ti_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .range_mode_i (range_mode_q),
    .vld_i        (base_vld),
    .base_i       (base),
    .oct_i        (base_oct),
    .vld_o        (post_vld),
    .angle_o      (post_angle)
  );

  // Output register with a one-beat skid behind it.
  always_comb begin
    take          = out_vld_q & out_ready_i;
    out_vld_d     = out_vld_q;
    skid_vld_d    = skid_vld_q;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_vld_q) begin
      if (take) begin
        load_out_skid = 1'b1;
        skid_vld_d    = 1'b0;
      end
    end else if (post_vld) begin
      if (!out_vld_q || take) begin
        load_out_pipe = 1'b1;
        out_vld_d     = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_pipe) begin
      out_angle_q <= post_angle;
    end else if (load_out_skid) begin
      out_angle_q <= skid_angle_q;
    end
    if (load_skid) begin
      skid_angle_q <= post_angle;
    end
  end

  assign out_valid_o = out_vld_q;
  assign angle_o     = out_angle_q;

endmodule

`default_nettype wire

@@ src/atan2ti_checker.sv @@
// -----------------------------------------------------------------------------
// atan2ti_checker
// Port-level checks of the atan2 unit, attached to the top level by bind.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "atan2_table_interpolated_unit_defines.svh"

module atan2ti_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic                          cfg_wdata_i,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic signed [SAMPLE_WIDTH-1:0] y_value_i,
  input wire logic signed [SAMPLE_WIDTH-1:0] x_value_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [17:0]            angle_o
);

  logic mode_q;
  logic unused;

  // Track the configured range from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign unused = in_valid_i ^ in_ready_o ^ (^y_value_i) ^ (^x_value_i);

  // A stalled result beat holds.
  `A2TI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(angle_o), "result beat changed while stalled")

  // Signed range keeps the angle within plus or minus pi.
  `A2TI_ASSERT_SAME(a_signed_range, out_valid_o && !mode_q,
                    (angle_o <= 18'sd51472) && (angle_o >= -18'sd51472),
                    "angle outside -pi..pi in signed range")

  // Lifted range keeps the angle within 0 and 2*pi, never negative.
  `A2TI_ASSERT_SAME(a_lifted_range, out_valid_o && mode_q,
                    (angle_o >= 18'sd0) && (angle_o <= 18'sd102944),
                    "angle outside 0..2pi in lifted range")

endmodule

bind atan2_table_interpolated_unit atan2ti_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_atan2ti_checker (.*);

`default_nettype wire

@@ tb/atan2_table_interpolated_unit_tb.sv @@
// -----------------------------------------------------------------------------
// atan2_table_interpolated_unit_tb
// Streams (y, x) sample pairs through the arctangent unit, predicts every
// angle with a behavioral model of the table and interpolation arithmetic,
// and compares each result beat in order under random stalls on both sides.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atan2_table_interpolated_unit_tb;
  import atan2ti_pkg::*;

  localparam int unsigned SW = 16;
  localparam int unsigned LATENCY = 31;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SW-1:0] y_value_i = '0;
  logic signed [SW-1:0] x_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OUTW-1:0] angle_o;

  // Predictor copy of the range register.
  logic mode_q = 1'b0;
  logic [OUTW-1:0] angle_queue[$];
  int errors = 0;
  int n_results = 0;
  bit quiet_tail = 1'b0;

  // Directed rows: y, x, and an expected angle when it is obvious.
  typedef struct {
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] x;
    bit has_exp;
    logic [OUTW-1:0] exp;
  } row_t;

  atan2_table_interpolated_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .y_value_i(y_value_i),
    .x_value_i(x_value_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .angle_o(angle_o)
  );

  always #5 clk_i = ~clk_i;

  // Base angle in nanoradians from the Q0.16 ratio.
  function automatic longint base_nano(longint unsigned z);
    longint unsigned scaled, a, idx, frac, lo, hi;
    scaled = z * 255;
    if (scaled < 65536) return longint'((z * 1000000000) >> 16);
    a = scaled - 32768;
    idx = a >> 16;
    frac = a & 16'hFFFF;
    if (idx > ROM_LEN - 2) idx = ROM_LEN - 2;
    lo = ATAN_ROM[idx];
    hi = ATAN_ROM[idx + 1];
    if (hi < lo) return longint'(lo);
    return longint'(lo + (((hi - lo) * frac) >> 16));
  endfunction

  // Full angle prediction in Q3.14, masked to the output width.
  function automatic logic [OUTW-1:0] predict_angle(logic signed [SW-1:0] ys,
                                                    logic signed [SW-1:0] xs, logic mode);
    longint y, x, ang, b;
    longint unsigned ya, xa, z, mag, q;
    y = ys;
    x = xs;
    ang = 0;
    if (y != 0 || x != 0) begin
      ya = (y < 0) ? -y : y;
      xa = (x < 0) ? -x : x;
      z = (ya < xa) ? (ya << 16) / xa : (xa << 16) / ya;
      b = base_nano(z);
      if (xa > ya) begin
        if (x >= 0) ang = (y >= 0) ? b : -b;
        else ang = (y >= 0) ? 64'sd3141592654 - b : b - 64'sd3141592654;
      end else begin
        if (y >= 0) ang = (x >= 0) ? 64'sd1570796327 - b : 64'sd1570796327 + b;
        else ang = (x >= 0) ? -64'sd1570796327 + b : -64'sd1570796327 - b;
      end
    end
    if (mode && ang < 0) ang += 64'sd6283185307;
    mag = (ang < 0) ? -ang : ang;
    q = (mag * 16384 + 500000000) / 1000000000;
    if (ang < 0) q = -q;
    return q[OUTW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [OUTW-1:0] got, logic [OUTW-1:0] want);
    errors++;
    $display("mismatch %s: angle got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  // Send one input beat; valid holds until it is accepted and drops only for an idle gap.
  task automatic send_pair(logic signed [SW-1:0] y, logic signed [SW-1:0] x);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    y_value_i <= y;
    x_value_i <= x;
    angle_queue.push_back(predict_angle(y, x, mode_q));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = v;
  endtask

  // Random pair: mostly full-range, some near axes, diagonals and extremes.
  task automatic send_random();
    logic signed [SW-1:0] y, x;
    y = SW'($urandom);
    x = SW'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        y = SW'($urandom_range(0, 20));
        if ($urandom_range(0, 1) == 0) y = -y;
      end
      1: begin
        x = SW'($urandom_range(0, 20));
        if ($urandom_range(0, 1) == 0) x = -x;
      end
      2: y = $urandom_range(0, 1) ? x : -x;
      3: begin
        y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      end
      default: ;
    endcase
    send_pair(y, x);
  endtask

  // Output side: random stall bursts, compare each accepted beat.
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected beat", angle_o, '0);
      end else begin
        logic [OUTW-1:0] want;
        want = angle_queue.pop_front();
        n_results++;
        if (angle_o !== want) report_mismatch("stream", angle_o, want);
      end
    end
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    rows = '{
      '{16'sd0, 16'sd0, 1, 18'd0},
      '{16'sd0, 16'sd100, 1, 18'd0},
      '{16'sd0, 16'sd32767, 1, 18'd0},
      '{16'sd1, 16'sd32767, 0, 0},
      '{16'sd100, 16'sd0, 1, 18'd25736},
      '{16'sd32767, 16'sd32767, 0, 0},
      '{-16'sd32768, -16'sd32768, 0, 0},
      '{16'sd0, -16'sd5, 1, 18'd51472},
      '{-16'sd5, 16'sd0, 0, 0},
      '{16'sd32767, -16'sd32768, 0, 0},
      '{-16'sd32768, 16'sd32767, 0, 0},
      '{-16'sd1, -16'sd32768, 0, 0},
      '{16'sd1, -16'sd32768, 0, 0},
      '{16'sd12345, -16'sd321, 0, 0},
      '{-16'sd300, 16'sd299, 0, 0},
      '{16'sd3, 16'sd700, 0, 0},
      '{-16'sd21845, -16'sd32768, 0, 0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass in each range setting, extremes of every sign.
    for (int m = 0; m < 2; m++) begin
      write_mode(m[0]);
      foreach (rows[i]) begin
        r = rows[i];
        send_pair(r.y, r.x);
        if (r.has_exp && m == 0 && angle_queue[$] !== r.exp)
          report_mismatch("directed table", angle_queue[$], r.exp);
      end
      drain_pipe();
    end

    // Random phases with mode changes; the sender waits out the pipe between.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(1'($urandom_range(0, 1)));
      if (ph == 5) quiet_tail = 1'b1;
      repeat (280) send_random();
      drain_pipe();
    end

    $display("covered %0d result beats over both range settings,", n_results);
    $display("directed extremes and random pairs with stalls on both sides.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
